// ===== src/hrhs_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhs_pkg
// Shared types and constants for the HTTP request header scanner.
// ----------------------------------------------------------------------------
`default_nettype none
package hrhs_pkg;

	localparam logic [1:0] VERB_GET  = 2'd0;
	localparam logic [1:0] VERB_POST = 2'd1;
	localparam logic [1:0] VERB_NONE = 2'd2;

	localparam logic [1:0] PH_PREFIX = 2'd0;
	localparam logic [1:0] PH_PATH   = 2'd1;
	localparam logic [1:0] PH_AFTER  = 2'd2;
	localparam logic [1:0] PH_ERROR  = 2'd3;

	localparam logic [2:0] NS_NONE  = 3'd0;
	localparam logic [2:0] NS_SKIP  = 3'd1;
	localparam logic [2:0] NS_SIGN  = 3'd2;
	localparam logic [2:0] NS_DIGIT = 3'd3;
	localparam logic [2:0] NS_DONE  = 3'd4;

	localparam int PAT_LEN = 15;
	localparam logic [31:0] MAG_CAP = 32'h8000_0000;

	// One result item as it travels through the output queue.
	typedef struct packed {
		logic        item_kind;
		logic [7:0]  path_char;
		logic [1:0]  method_code;
		logic        parse_status;
		logic [7:0]  path_count;
		logic [31:0] body_length_value;
		logic        body_marker_seen;
		logic [15:0] body_offset;
		logic        request_overlong;
	} result_t;

	// State of one Content-Length search.
	typedef struct packed {
		logic [3:0]  match;
		logic [2:0]  nstate;
		logic [31:0] mag;
		logic        neg;
	} cl_scan_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] pat_char(input logic upper, input logic [3:0] i);
		logic [7:0] ch;
		case (i)
			4'd0:  ch = upper ? "C" : "c";
			4'd1:  ch = "o";
			4'd2:  ch = "n";
			4'd3:  ch = "t";
			4'd4:  ch = "e";
			4'd5:  ch = "n";
			4'd6:  ch = "t";
			4'd7:  ch = "-";
			4'd8:  ch = upper ? "L" : "l";
			4'd9:  ch = "e";
			4'd10: ch = "n";
			4'd11: ch = "g";
			4'd12: ch = "t";
			4'd13: ch = "h";
			4'd14: ch = ":";
			default: ch = 8'd0;
		endcase
		return ch;
	endfunction

	function automatic cl_scan_t cl_step(input cl_scan_t s, input logic upper,
			input logic [7:0] c);
		cl_scan_t n;
		logic digit;
		logic [35:0] prod;
		logic number;
		n = s;
		digit = (c >= "0") && (c <= "9");
		number = 1'b0;
		case (s.nstate)
			NS_NONE: begin
				if (c == pat_char(upper, s.match)) n.match = s.match + 4'd1;
				else n.match = (c == pat_char(upper, 4'd0)) ? 4'd1 : 4'd0;
				if (n.match >= 4'(PAT_LEN)) n.nstate = NS_SKIP;
			end
			NS_SKIP: begin
				if (is_ws(c)) n = s;
				else if (c == "+") n.nstate = NS_SIGN;
				else if (c == "-") begin
					n.neg = 1'b1;
					n.nstate = NS_SIGN;
				end else number = 1'b1;
			end
			NS_SIGN, NS_DIGIT: number = 1'b1;
			default: n = s;
		endcase
		if (number) begin
			if (digit) begin
				prod = {1'b0, s.mag, 3'b000} + {3'b000, s.mag, 1'b0} + 36'(c - "0");
				n.mag = (prod > 36'(MAG_CAP)) ? MAG_CAP : prod[31:0];
				n.nstate = NS_DIGIT;
			end else n.nstate = NS_DONE;
		end
		return n;
	endfunction

	function automatic logic [31:0] cl_value(input cl_scan_t s);
		logic [31:0] v;
		if (s.nstate != NS_DIGIT && s.nstate != NS_DONE) v = 32'd0;
		else if (s.neg) v = 32'd0 - s.mag;
		else v = (s.mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : s.mag;
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== src/hrhs_front.sv =====
// ----------------------------------------------------------------------------
// hrhs_front
// Classifies each request byte and updates the scan state; emits result items.
// ----------------------------------------------------------------------------
`default_nettype none
module hrhs_front import hrhs_pkg::*; #(
	parameter int PATH_BYTES  = 256,
	parameter int OFFSET_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output result_t         res_a,
	output logic            res_a_valid,
	output result_t         res_b,
	output logic            res_b_valid
);

	localparam int PKW = $clog2(PATH_BYTES);
	localparam logic [PKW-1:0] PATH_MAX = PKW'(PATH_BYTES - 1);
	localparam int OFW = (OFFSET_BITS > 16) ? 16 : OFFSET_BITS;
	localparam logic [40:0] OFF_MAX = 41'((64'd1 << OFW) - 64'd1);
	localparam logic [39:0] POS_CAP = 40'hFF_FFFF_FFFF;

	logic [1:0]     phase_q;
	logic [2:0]     pidx_q;
	logic [1:0]     method_q;
	logic [PKW-1:0] kept_q;
	cl_scan_t       up_q, lo_q;
	logic [2:0]     blank_q;
	logic [39:0]    pos_q;
	logic [15:0]    moff_q;
	logic           mseen_q, over_q, ended_q;

	logic [1:0]     phase_d;
	logic [2:0]     pidx_d;
	logic [1:0]     method_d;
	logic [PKW-1:0] kept_d;
	cl_scan_t       up_d, lo_d;
	logic [2:0]     blank_d;
	logic [15:0]    moff_d;
	logic           mseen_d, over_d, ended_d, emit_path;
	logic [7:0]     pre_ch;
	logic [2:0]     pre_len;
	logic [7:0]     want;

	always_comb begin
		phase_d = phase_q; pidx_d = pidx_q; method_d = method_q; kept_d = kept_q;
		up_d = up_q; lo_d = lo_q; blank_d = blank_q; moff_d = moff_q;
		mseen_d = mseen_q; over_d = over_q; ended_d = ended_q; emit_path = 1'b0;
		pre_len = (method_q == VERB_POST) ? 3'd5 : 3'd4;
		case (pidx_q)
			3'd1: pre_ch = (method_q == VERB_POST) ? "O" : "E";
			3'd2: pre_ch = (method_q == VERB_POST) ? "S" : "T";
			3'd3: pre_ch = (method_q == VERB_POST) ? "T" : " ";
			3'd4: pre_ch = " ";
			default: pre_ch = 8'd0;
		endcase
		want = blank_q[0] ? 8'h0A : 8'h0D;
		if (!ended_q) begin
			if ({1'b0, pos_q} > OFF_MAX) over_d = 1'b1;
			if (data_byte == 8'd0) ended_d = 1'b1;
			if (phase_q == PH_PREFIX) begin
				if (pidx_q == 3'd0) begin
					if (data_byte == "G") begin
						method_d = VERB_GET; pidx_d = 3'd1;
					end else if (data_byte == "P") begin
						method_d = VERB_POST; pidx_d = 3'd1;
					end else phase_d = PH_ERROR;
				end else if (pidx_q < pre_len && data_byte == pre_ch) begin
					pidx_d = pidx_q + 3'd1;
					if (pidx_d >= pre_len) phase_d = PH_PATH;
				end else phase_d = PH_ERROR;
			end else if (phase_q == PH_PATH) begin
				if (data_byte != 8'd0 && !is_ws(data_byte) && kept_q < PATH_MAX) begin
					kept_d = kept_q + PKW'(1);
					emit_path = 1'b1;
				end else phase_d = PH_AFTER;
			end
			if (data_byte != 8'd0) begin
				up_d = cl_step(up_q, 1'b1, data_byte);
				lo_d = cl_step(lo_q, 1'b0, data_byte);
				if (blank_q < 3'd4) begin
					if (data_byte == want) blank_d = blank_q + 3'd1;
					else blank_d = (data_byte == 8'h0D) ? 3'd1 : 3'd0;
					if (blank_d == 3'd4) begin
						moff_d = ({1'b0, pos_q} + 41'd1 > OFF_MAX) ? OFF_MAX[15:0]
							: 16'(pos_q + 40'd1);
						mseen_d = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		res_a = '0;
		res_a.path_char = data_byte;
		res_a_valid = emit_path;
		res_b = '0;
		res_b.item_kind = 1'b1;
		res_b.request_overlong = over_d;
		if (phase_d == PH_PATH || phase_d == PH_AFTER) begin
			res_b.method_code = method_d;
			res_b.path_count = (kept_d > PKW'(255)) ? 8'd255 : 8'(kept_d);
			if (method_d == VERB_POST)
				res_b.body_length_value = (up_d.nstate != NS_NONE) ? cl_value(up_d)
					: cl_value(lo_d);
			res_b.body_marker_seen = mseen_d;
			res_b.body_offset = moff_d;
		end else begin
			res_b.method_code = VERB_NONE;
			res_b.parse_status = 1'b1;
		end
		res_b_valid = final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX; pidx_q <= '0; method_q <= VERB_NONE;
			kept_q <= '0; up_q <= '0; lo_q <= '0; blank_q <= '0; pos_q <= '0;
			moff_q <= '0; mseen_q <= 1'b0; over_q <= 1'b0; ended_q <= 1'b0;
		end else if (step) begin
			if (final_byte) begin
				phase_q <= PH_PREFIX; pidx_q <= '0; method_q <= VERB_NONE;
				kept_q <= '0; up_q <= '0; lo_q <= '0; blank_q <= '0; pos_q <= '0;
				moff_q <= '0; mseen_q <= 1'b0; over_q <= 1'b0; ended_q <= 1'b0;
			end else begin
				phase_q <= phase_d; pidx_q <= pidx_d; method_q <= method_d;
				kept_q <= kept_d; up_q <= up_d; lo_q <= lo_d; blank_q <= blank_d;
				moff_q <= moff_d; mseen_q <= mseen_d; over_q <= over_d;
				ended_q <= ended_d;
				if (!ended_q && data_byte != 8'd0 && pos_q < POS_CAP)
					pos_q <= pos_q + 40'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/hrhs_queue.sv =====
// ----------------------------------------------------------------------------
// hrhs_queue
// Small result queue that takes up to two items per cycle and gives one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
`default_nettype none
module hrhs_queue import hrhs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  result_t   wr_a,
	input  wire logic wr_a_en,
	input  result_t   wr_b,
	input  wire logic wr_b_en,
	output logic      room,
	output result_t   rd_data,
	output logic      rd_valid,
	input  wire logic rd_ready
);

	result_t    mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [2:0] nwr;

	assign pop      = rd_valid && rd_ready;
	assign rd_valid = cnt_q != 3'd0;
	assign rd_data  = mem_q[rp_q];
	// Two free slots are needed since one transaction can produce two items.
	assign room     = cnt_q <= 3'd2;
	assign nwr      = {2'b00, wr_a_en} + {2'b00, wr_b_en};

	always_ff @(posedge clk) begin
		if (wr_a_en) mem_q[wp_q] <= wr_a;
		if (wr_b_en) mem_q[wp_q + {1'b0, wr_a_en}] <= wr_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + nwr[1:0];
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + nwr - {2'b00, pop};
		end
	end

endmodule
`default_nettype wire

// ===== src/http_request_header_scanner.sv =====
// ----------------------------------------------------------------------------
// http_request_header_scanner
// Streaming scanner for an HTTP request line and its Content-Length header.
// ----------------------------------------------------------------------------
// Request bytes enter on the input channel (data_byte, final_byte) under
// valid/ready; one byte is taken per cycle while in_ready is high. Each
// path byte, up to PATH_BYTES-1 per request, produces one result transaction
// with item_kind 0, and the final byte of a request produces a summary
// transaction with item_kind 1, so one input can give two results. The front
// scanner updates all state in the cycle a byte is taken and writes its
// results into a four-entry queue that drives the output. Throughput is one
// byte per cycle while the receiver keeps up. When the receiver stalls, the
// queue fills and in_ready drops once fewer than two slots are free. Reset
// clears the scan state and empties the queue, which leaves the block ready.
// ----------------------------------------------------------------------------
`default_nettype none
module http_request_header_scanner import hrhs_pkg::*; #(
	parameter int PATH_BYTES  = 256,
	parameter int OFFSET_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             item_kind,
	output logic [7:0]       path_char,
	output logic [1:0]       method_code,
	output logic             parse_status,
	output logic [7:0]       path_count,
	output logic [31:0]      body_length_value,
	output logic             body_marker_seen,
	output logic [15:0]      body_offset,
	output logic             request_overlong
);

	result_t res_a, res_b, rd;
	logic    a_v, b_v, step;

	assign step = in_valid && in_ready;

	hrhs_front #(.PATH_BYTES(PATH_BYTES), .OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk, .arst_n, .step, .data_byte, .final_byte,
		.res_a, .res_a_valid(a_v), .res_b, .res_b_valid(b_v)
	);

	hrhs_queue u_queue (
		.clk, .arst_n,
		.wr_a(res_a), .wr_a_en(step && a_v),
		.wr_b(res_b), .wr_b_en(step && b_v),
		.room(in_ready), .rd_data(rd), .rd_valid(out_valid), .rd_ready(out_ready)
	);

	assign item_kind         = rd.item_kind;
	assign path_char         = rd.path_char;
	assign method_code       = rd.method_code;
	assign parse_status      = rd.parse_status;
	assign path_count        = rd.path_count;
	assign body_length_value = rd.body_length_value;
	assign body_marker_seen  = rd.body_marker_seen;
	assign body_offset       = rd.body_offset;
	assign request_overlong  = rd.request_overlong;

endmodule
`default_nettype wire
